@@ src/fixed_point_layer_norm_defines.svh @@
// assertion macros shared by the checker
// no dependencies
`ifndef FIXED_POINT_LAYER_NORM_DEFINES_SVH
`define FIXED_POINT_LAYER_NORM_DEFINES_SVH

// checked only outside reset
`define FPLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define FPLN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/fpln_pkg.sv @@
// shared types and constants for the fixed-point layer norm block
// no dependencies
package fpln_pkg;

  localparam int X_W          = 25;
  localparam int Y_W          = 32;
  localparam int LIM_W        = 31;
  localparam int DIV_NW       = 64;
  localparam int DIV_DW       = 32;
  localparam int NEWTON_STEPS = 8;

  localparam logic [DIV_DW-1:0] SCALE      = 32'd59049;
  localparam logic [DIV_NW-1:0] SCALE_SQ   = 64'd3486784401;
  localparam logic [DIV_NW-1:0] VAR_BIAS   = 64'd35;
  localparam logic [15:0]       HALF_SCALE = 16'd29524;

  // ceil(2^48 / scale), exact for 32-bit dividends below scale * 2^16
  localparam logic [32:0] RECIP_SCALE =
    33'(((65'd1 << 48) + 65'(SCALE) - 65'd1) / 65'(SCALE));

  localparam logic [LIM_W-1:0] CLAMP_RESET = 31'h7FFF_FFFF;

  // register index as seen on paddr[2]
  localparam logic CFG_CLAMP_LIMIT = 1'b0;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_MEAN_GO,
    B_MEAN_WAIT,
    B_V_RD,
    B_V_DIFF,
    B_V_MUL,
    B_V_ACC,
    B_VAR_GO,
    B_VAR_WAIT,
    B_LOG,
    B_NEWT_GO,
    B_NEWT_WAIT,
    B_RSTD_GO,
    B_RSTD_WAIT,
    B_O_RD,
    B_O_CEN,
    B_O_MUL1,
    B_O_DIV1_GO,
    B_O_DIV1_WAIT,
    B_O_MUL2,
    B_O_DIV2_GO,
    B_O_DIV2_WAIT,
    B_O_PUSH
  } bstate_t;

endpackage

@@ src/fpln_ram.sv @@
// generic simple dual-port ram with registered read
// no dependencies
module fpln_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fpln_div.sv @@
// shared unsigned restoring divider, one quotient bit per cycle
// depends on fpln_pkg
module fpln_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fpln_pkg::DIV_NW-1:0]  num,
  input  logic [fpln_pkg::DIV_DW-1:0]  den,
  output logic                         done,
  output logic [fpln_pkg::DIV_NW-1:0]  quo
);

  localparam int CNT_W = $clog2(fpln_pkg::DIV_NW + 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [fpln_pkg::DIV_DW-1:0] rem;
  logic [fpln_pkg::DIV_DW-1:0] dreg;
  logic [fpln_pkg::DIV_DW:0]   shifted;
  logic                        fits;

  assign shifted = {rem, quo[fpln_pkg::DIV_NW-1]};
  assign fits    = shifted >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(fpln_pkg::DIV_NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem <= fits ? fpln_pkg::DIV_DW'(shifted - {1'b0, dreg})
                  : shifted[fpln_pkg::DIV_DW-1:0];
      quo <= {quo[fpln_pkg::DIV_NW-2:0], fits};
    end
  end

endmodule

@@ src/fpln_queue.sv @@
// two-entry transaction queue between the load side and the compute side
// no dependencies
module fpln_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;

  assign not_full  = fill != 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

@@ src/fpln_front.sv @@
// load side: stores row elements into a ping-pong buffer and queues finished rows
// depends on fpln_pkg
module fpln_front #(
  parameter int MAX_COLS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic signed [fpln_pkg::X_W-1:0]    x_value,
  input  logic signed [fpln_pkg::X_W-1:0]    gain,
  input  logic signed [fpln_pkg::X_W-1:0]    offset,
  input  logic                               last_in_row,
  output logic                               we,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1):0] waddr,
  output logic [3*fpln_pkg::X_W-1:0]         wdata,
  output logic                               push,
  output logic [$clog2(MAX_COLS+1)+fpln_pkg::X_W+$clog2(MAX_COLS+1):0] push_data,
  input  logic                               q_not_full,
  input  fpln_pkg::rel_t                     rel
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW = fpln_pkg::X_W + CW;

  logic [CW-1:0]        count;
  logic signed [SW-1:0] sum;
  logic                 wbank;
  logic [1:0]           busy;
  logic                 take;
  logic                 row_end;
  logic signed [SW-1:0] sum_next;
  logic [CW-1:0]        n_next;

  assign item_ready = !busy[wbank] && q_not_full;
  assign take       = item_valid && item_ready;
  assign row_end    = last_in_row || (count == CW'(MAX_COLS - 1));
  assign sum_next   = sum + SW'(x_value);
  assign n_next     = count + CW'(1);

  assign we        = take;
  assign waddr     = {wbank, count[IW-1:0]};
  assign wdata     = {x_value, gain, offset};
  assign push      = take && row_end;
  assign push_data = {wbank, n_next, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      wbank <= 1'b0;
      busy  <= 2'b00;
    end else begin
      if (rel.valid) begin
        busy[rel.bank] <= 1'b0;
      end
      if (take) begin
        if (row_end) begin
          count       <= '0;
          sum         <= '0;
          wbank       <= ~wbank;
          busy[wbank] <= 1'b1;
        end else begin
          count <= n_next;
          sum   <= sum_next;
        end
      end
    end
  end

endmodule

@@ src/fpln_back.sv @@
// compute side: mean, variance, square root, reciprocal and per-column outputs
// depends on fpln_pkg; drives the shared divider and the buffer read port
module fpln_back #(
  parameter int MAX_COLS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_not_empty,
  input  logic [$clog2(MAX_COLS+1)+fpln_pkg::X_W+$clog2(MAX_COLS+1):0] q_data,
  output logic                                 q_pop,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1):0] raddr,
  input  logic [3*fpln_pkg::X_W-1:0]           rdata,
  output logic                                 div_start,
  output logic [fpln_pkg::DIV_NW-1:0]          div_num,
  output logic [fpln_pkg::DIV_DW-1:0]          div_den,
  input  logic                                 div_done,
  input  logic [fpln_pkg::DIV_NW-1:0]          div_quo,
  input  logic [fpln_pkg::LIM_W-1:0]           clamp_limit,
  output fpln_pkg::rel_t                       rel,
  output logic signed [fpln_pkg::Y_W-1:0]      y_value,
  output logic                                 last_out,
  output logic                                 result_valid,
  input  logic                                 result_ready
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW = fpln_pkg::X_W + CW;
  localparam int XW = fpln_pkg::X_W;
  localparam int NW = fpln_pkg::DIV_NW;
  localparam int DW = fpln_pkg::DIV_DW;

  fpln_pkg::bstate_t state, state_next;

  logic                 bank;
  logic [CW-1:0]        n;
  logic signed [SW-1:0] sum;
  logic [CW-1:0]        j;
  logic signed [26:0]   mean;
  logic signed [26:0]   d;
  logic [53:0]          sq;
  logic [NW-1:0]        var_sum;
  logic [NW-1:0]        vr;
  logic [NW-1:0]        t;
  logic [5:0]           bits;
  logic [DW-1:0]        y;
  logic [2:0]           it;
  logic [30:0]          rstd;
  logic signed [26:0]   cen;
  logic signed [XW-1:0] gain_r;
  logic signed [XW-1:0] off_r;
  logic signed [58:0]   p;
  logic signed [31:0]   norm;
  logic signed [57:0]   q2;
  logic signed [43:0]   tq;

  logic signed [XW-1:0] rx;
  logic signed [XW-1:0] rg;
  logic signed [XW-1:0] ro;
  logic [SW-1:0]        sum_abs;
  logic [58:0]          p_abs;
  logic [57:0]          q2_abs;
  logic [NW:0]          nsum;
  logic [NW-1:0]        ny;
  logic                 ny_stop;
  logic                 slot_free;
  logic                 last_col;
  logic signed [44:0]   r;
  logic signed [44:0]   lim;
  logic signed [44:0]   r_clamped;
  logic [5:0]           half_bits;

  // division by the scale, 16-bit digits by reciprocal multiply
  logic                 cd_start;
  logic [NW-1:0]        cd_in;
  logic                 cd_busy;
  logic                 cd_done;
  logic                 cd_phase;
  logic [1:0]           cd_cnt;
  logic [NW-1:0]        cd_num;
  logic [15:0]          cd_rem;
  logic [NW-1:0]        cd_quo;
  logic [63:0]          cd_prod;
  logic [31:0]          cd_v;
  logic [15:0]          cd_q;
  logic [31:0]          cd_qd;

  assign rx = rdata[3*XW-1:2*XW];
  assign rg = rdata[2*XW-1:XW];
  assign ro = rdata[XW-1:0];

  assign sum_abs   = sum[SW-1] ? SW'(-sum) : sum;
  assign p_abs     = p[58] ? 59'(-p) : 59'(p);
  assign q2_abs    = q2[57] ? 58'(-q2) : 58'(q2);
  assign nsum      = {1'b0, div_quo} + (NW+1)'(y);
  assign ny        = nsum[NW:1];
  assign ny_stop   = ny >= NW'(y);
  assign slot_free = !result_valid || result_ready;
  assign last_col  = j == (n - CW'(1));
  assign half_bits = (bits + 6'd1) >> 1;

  assign cd_v  = {cd_rem, cd_num[NW-1:NW-16]};
  assign cd_q  = cd_prod[63:48];
  assign cd_qd = 32'(cd_q) * fpln_pkg::SCALE;

  assign r   = 45'(tq) + 45'(off_r);
  assign lim = $signed({14'd0, clamp_limit});
  always_comb begin
    priority if (r > lim) begin
      r_clamped = lim;
    end else if (r < -lim) begin
      r_clamped = -lim;
    end else begin
      r_clamped = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_busy  <= 1'b0;
      cd_done  <= 1'b0;
      cd_phase <= 1'b0;
      cd_cnt   <= '0;
    end else begin
      cd_done <= cd_busy && cd_phase && (cd_cnt == 2'd3);
      if (cd_start) begin
        cd_busy  <= 1'b1;
        cd_phase <= 1'b0;
        cd_cnt   <= '0;
      end else if (cd_busy) begin
        cd_phase <= ~cd_phase;
        if (cd_phase) begin
          cd_cnt <= cd_cnt + 2'd1;
          if (cd_cnt == 2'd3) begin
            cd_busy <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cd_start) begin
      cd_num <= cd_in;
      cd_rem <= '0;
    end else if (cd_busy) begin
      if (!cd_phase) begin
        cd_prod <= 64'(cd_v) * 64'(fpln_pkg::RECIP_SCALE);
      end else begin
        cd_rem <= 16'(cd_v - cd_qd);
        cd_quo <= {cd_quo[NW-17:0], cd_q};
        cd_num <= {cd_num[NW-17:0], 16'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpln_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpln_pkg::B_IDLE:        if (q_not_empty) state_next = fpln_pkg::B_MEAN_GO;
      fpln_pkg::B_MEAN_GO:     state_next = fpln_pkg::B_MEAN_WAIT;
      fpln_pkg::B_MEAN_WAIT:   if (div_done) state_next = fpln_pkg::B_V_RD;
      fpln_pkg::B_V_RD:        state_next = fpln_pkg::B_V_DIFF;
      fpln_pkg::B_V_DIFF:      state_next = fpln_pkg::B_V_MUL;
      fpln_pkg::B_V_MUL:       state_next = fpln_pkg::B_V_ACC;
      fpln_pkg::B_V_ACC: begin
        state_next = last_col ? fpln_pkg::B_VAR_GO : fpln_pkg::B_V_RD;
      end
      fpln_pkg::B_VAR_GO:      state_next = fpln_pkg::B_VAR_WAIT;
      fpln_pkg::B_VAR_WAIT:    if (div_done) state_next = fpln_pkg::B_LOG;
      fpln_pkg::B_LOG: begin
        if (t[NW-1:1] == '0) state_next = fpln_pkg::B_NEWT_GO;
      end
      fpln_pkg::B_NEWT_GO:     state_next = fpln_pkg::B_NEWT_WAIT;
      fpln_pkg::B_NEWT_WAIT: begin
        if (div_done) begin
          if (ny_stop || it == 3'(fpln_pkg::NEWTON_STEPS - 1)) begin
            state_next = fpln_pkg::B_RSTD_GO;
          end else begin
            state_next = fpln_pkg::B_NEWT_GO;
          end
        end
      end
      fpln_pkg::B_RSTD_GO:     state_next = fpln_pkg::B_RSTD_WAIT;
      fpln_pkg::B_RSTD_WAIT:   if (div_done) state_next = fpln_pkg::B_O_RD;
      fpln_pkg::B_O_RD:        state_next = fpln_pkg::B_O_CEN;
      fpln_pkg::B_O_CEN:       state_next = fpln_pkg::B_O_MUL1;
      fpln_pkg::B_O_MUL1:      state_next = fpln_pkg::B_O_DIV1_GO;
      fpln_pkg::B_O_DIV1_GO:   state_next = fpln_pkg::B_O_DIV1_WAIT;
      fpln_pkg::B_O_DIV1_WAIT: if (cd_done) state_next = fpln_pkg::B_O_MUL2;
      fpln_pkg::B_O_MUL2:      state_next = fpln_pkg::B_O_DIV2_GO;
      fpln_pkg::B_O_DIV2_GO:   state_next = fpln_pkg::B_O_DIV2_WAIT;
      fpln_pkg::B_O_DIV2_WAIT: if (cd_done) state_next = fpln_pkg::B_O_PUSH;
      fpln_pkg::B_O_PUSH: begin
        if (slot_free) begin
          state_next = last_col ? fpln_pkg::B_IDLE : fpln_pkg::B_O_RD;
        end
      end
      default:                 state_next = fpln_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cd_start  = 1'b0;
    cd_in     = '0;
    rel.valid = 1'b0;
    rel.bank  = bank;
    raddr     = {bank, j[IW-1:0]};
    unique case (state)
      fpln_pkg::B_IDLE: q_pop = q_not_empty;
      fpln_pkg::B_MEAN_GO: begin
        div_start = 1'b1;
        div_num   = NW'(sum_abs);
        div_den   = DW'(n);
      end
      fpln_pkg::B_VAR_GO: begin
        div_start = 1'b1;
        div_num   = var_sum;
        div_den   = DW'(n);
      end
      fpln_pkg::B_NEWT_GO: begin
        div_start = 1'b1;
        div_num   = vr;
        div_den   = y;
      end
      fpln_pkg::B_RSTD_GO: begin
        div_start = 1'b1;
        div_num   = fpln_pkg::SCALE_SQ;
        div_den   = y;
      end
      fpln_pkg::B_O_DIV1_GO: begin
        cd_start = 1'b1;
        cd_in    = NW'(p_abs);
      end
      fpln_pkg::B_O_DIV2_GO: begin
        cd_start = 1'b1;
        cd_in    = NW'(q2_abs);
      end
      fpln_pkg::B_O_PUSH: rel.valid = slot_free && last_col;
      default: begin
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      fpln_pkg::B_IDLE: begin
        {bank, n, sum} <= q_data;
        j              <= '0;
        var_sum        <= '0;
      end
      fpln_pkg::B_MEAN_WAIT: begin
        mean <= sum[SW-1] ? -$signed(div_quo[26:0]) : $signed(div_quo[26:0]);
      end
      fpln_pkg::B_V_DIFF: d <= 27'(rx) - mean;
      fpln_pkg::B_V_MUL:  sq <= 54'(d * d);
      fpln_pkg::B_V_ACC: begin
        var_sum <= var_sum + NW'(sq);
        j       <= last_col ? '0 : j + CW'(1);
      end
      fpln_pkg::B_VAR_WAIT: begin
        vr   <= div_quo + fpln_pkg::VAR_BIAS;
        t    <= div_quo + fpln_pkg::VAR_BIAS;
        bits <= '0;
      end
      fpln_pkg::B_LOG: begin
        if (t[NW-1:1] != '0) begin
          t    <= t >> 1;
          bits <= bits + 6'd1;
        end else begin
          y  <= DW'(1) << half_bits;
          it <= '0;
        end
      end
      fpln_pkg::B_NEWT_WAIT: begin
        if (div_done) begin
          if (!ny_stop) begin
            y <= ny[DW-1:0];
          end
          it <= it + 3'd1;
        end
      end
      fpln_pkg::B_RSTD_WAIT: rstd <= div_quo[30:0];
      fpln_pkg::B_O_CEN: begin
        cen    <= 27'(rx) - mean;
        gain_r <= rg;
        off_r  <= ro;
      end
      fpln_pkg::B_O_MUL1: p <= 59'(cen * $signed({1'b0, rstd}));
      fpln_pkg::B_O_DIV1_WAIT: begin
        norm <= p[58] ? -$signed(cd_quo[31:0]) : $signed(cd_quo[31:0]);
      end
      fpln_pkg::B_O_MUL2: begin
        q2 <= 58'(norm * gain_r) + 58'(fpln_pkg::HALF_SCALE);
      end
      fpln_pkg::B_O_DIV2_WAIT: begin
        tq <= q2[57] ? -$signed(cd_quo[43:0]) : $signed(cd_quo[43:0]);
      end
      fpln_pkg::B_O_PUSH: begin
        if (slot_free) begin
          j <= j + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == fpln_pkg::B_O_PUSH && slot_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fpln_pkg::B_O_PUSH && slot_free) begin
      y_value  <= r_clamped[fpln_pkg::Y_W-1:0];
      last_out <= last_col;
    end
  end

endmodule

@@ src/fixed_point_layer_norm.sv @@
// Fixed-point layer normalization over one row of up to MAX_COLS elements.
// Elements load at one transaction per cycle, while item_ready is high, into
// a ping-pong buffer; the element flagged last_in_row (or the one that fills
// MAX_COLS) queues the row for the compute side, and loading of the next row
// goes on into the other bank; it stalls while both banks hold outstanding
// rows. Divisions by the row length and those of the square root and
// reciprocal share one divider, so per row the compute side runs the mean
// division, the variance pass, the variance division, the guess, the Newton
// steps of the square root and the reciprocal division in turn. The two
// divisions by the scale in each output use reciprocal multiply, and each
// output may wait on the output register. Results leave in column order.
// depends on fpln_pkg, fpln_front, fpln_ram, fpln_queue, fpln_div and fpln_back
module fixed_point_layer_norm #(
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic signed [fpln_pkg::X_W-1:0] x_value,
  input  logic signed [fpln_pkg::X_W-1:0] gain,
  input  logic signed [fpln_pkg::X_W-1:0] offset,
  input  logic                            last_in_row,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic signed [fpln_pkg::Y_W-1:0] y_value,
  output logic                            last_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int JW = 1 + CW + fpln_pkg::X_W + CW;

  logic [fpln_pkg::LIM_W-1:0] clamp_limit;

  logic                         we;
  logic [IW:0]                  waddr;
  logic [3*fpln_pkg::X_W-1:0]   wdata;
  logic [IW:0]                  raddr;
  logic [3*fpln_pkg::X_W-1:0]   rdata;
  logic                         push;
  logic [JW-1:0]                push_data;
  logic                         q_not_full;
  logic                         q_pop;
  logic                         q_not_empty;
  logic [JW-1:0]                q_data;
  logic                         div_start;
  logic [fpln_pkg::DIV_NW-1:0]  div_num;
  logic [fpln_pkg::DIV_DW-1:0]  div_den;
  logic                         div_done;
  logic [fpln_pkg::DIV_NW-1:0]  div_quo;
  fpln_pkg::rel_t               rel;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fpln_pkg::CFG_CLAMP_LIMIT) ? {1'b0, clamp_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_limit <= fpln_pkg::CLAMP_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == fpln_pkg::CFG_CLAMP_LIMIT) begin
      clamp_limit <= pwdata[fpln_pkg::LIM_W-1:0];
    end
  end

  fpln_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .x_value     (x_value),
    .gain        (gain),
    .offset      (offset),
    .last_in_row (last_in_row),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .push        (push),
    .push_data   (push_data),
    .q_not_full  (q_not_full),
    .rel         (rel)
  );

  fpln_ram #(.WIDTH(3*fpln_pkg::X_W), .DEPTH(2*(1 << IW))) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  fpln_queue #(.W(JW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  fpln_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  fpln_back #(.MAX_COLS(MAX_COLS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .raddr        (raddr),
    .rdata        (rdata),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .clamp_limit  (clamp_limit),
    .rel          (rel),
    .y_value      (y_value),
    .last_out     (last_out),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

@@ src/fpln_checker.sv @@
// port-level checker for the layer norm block, bound to the top level
// depends on fixed_point_layer_norm_defines.svh
`include "fixed_point_layer_norm_defines.svh"

module fpln_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] y_value,
  input logic        last_out
);

  `FPLN_ASSERT(a_hold_valid, result_valid && !result_ready |=> result_valid, "result dropped")
  `FPLN_ASSERT(a_hold_data, result_valid && !result_ready |=> $stable(y_value) && $stable(last_out), "result changed while stalled")
  `FPLN_ASSERT(a_no_min, result_valid |-> y_value != 32'h8000_0000, "result outside clamp range")
  `FPLN_ASSERT_ALWAYS(a_reset_quiet, rst |=> !result_valid, "result transaction right after reset")

endmodule

bind fixed_point_layer_norm fpln_checker u_chk (.*);
